FILE: sv/mtg_pkg.sv
package mtg_pkg;

  localparam int WORD_W = 32;
  localparam int TBL_LEN = 624;
  localparam int TBL_SHIFT = 397;
  localparam int IDX_W = $clog2(TBL_LEN);

  localparam logic [WORD_W-1:0] LCG_MUL = 32'd69069;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
  localparam logic [WORD_W-1:0] TWIST_MAT = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] UPPER_MASK = ~LOWER_MASK;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } word_push_t;

  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    word_t v;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    v = far ^ (y >> 1);
    if (nxt[0]) begin
      v = v ^ TWIST_MAT;
    end
    return v;
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: sv/mtg_ram.sv
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: sv/mtg_engine.sv
module mtg_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  mtg_pkg::word_t       cfg_wdata,
  input  mtg_pkg::fifo_cnt_t   fifo_count,
  output logic                 fill_busy,
  output mtg_pkg::word_push_t  push
);

  logic                fill_active;
  mtg_pkg::idx_t       fill_idx;
  mtg_pkg::word_t      lcg_x;
  mtg_pkg::word_t      lcg_next;
  mtg_pkg::idx_t       gen_idx;
  mtg_pkg::idx_t       gen_idx_next;
  mtg_pkg::word_t      cur;
  logic                s1_v;
  mtg_pkg::idx_t       s1_idx;
  logic                s2_v;
  mtg_pkg::word_t      s2_word;
  logic                issue;
  logic [mtg_pkg::FIFO_CNT_W:0] pending;
  logic [mtg_pkg::IDX_W:0] far_sum;
  mtg_pkg::idx_t       addr_a;
  mtg_pkg::idx_t       addr_b;
  mtg_pkg::word_t      rd_a;
  mtg_pkg::word_t      rd_b;
  mtg_pkg::word_t      twist_v;
  logic                ram_we;
  mtg_pkg::idx_t       ram_waddr;
  mtg_pkg::word_t      ram_wdata;

  assign lcg_next = lcg_x * mtg_pkg::LCG_MUL;

  // Count words already queued or still in flight so the queue never overflows.
  assign pending = (mtg_pkg::FIFO_CNT_W + 1)'(fifo_count)
                 + (mtg_pkg::FIFO_CNT_W + 1)'(s1_v)
                 + (mtg_pkg::FIFO_CNT_W + 1)'(s2_v);
  assign issue = !fill_active && !cfg_wen
               && (pending < (mtg_pkg::FIFO_CNT_W + 1)'(mtg_pkg::FIFO_DEPTH));

  assign gen_idx_next = (gen_idx == mtg_pkg::IDX_W'(mtg_pkg::TBL_LEN - 1))
                      ? '0 : gen_idx + 1'b1;
  assign addr_a = gen_idx_next;
  assign far_sum = (mtg_pkg::IDX_W + 1)'(gen_idx) + (mtg_pkg::IDX_W + 1)'(mtg_pkg::TBL_SHIFT);
  assign addr_b = (far_sum >= (mtg_pkg::IDX_W + 1)'(mtg_pkg::TBL_LEN))
                ? mtg_pkg::IDX_W'(far_sum - (mtg_pkg::IDX_W + 1)'(mtg_pkg::TBL_LEN))
                : mtg_pkg::IDX_W'(far_sum);

  // cur holds the old value of entry k, taken from the previous step's next read.
  assign twist_v = mtg_pkg::twist_word(cur, rd_a, rd_b);

  assign ram_we = fill_active || s1_v;
  assign ram_waddr = fill_active ? fill_idx : s1_idx;
  assign ram_wdata = fill_active ? lcg_x : twist_v;

  mtg_ram #(
    .WIDTH(mtg_pkg::WORD_W),
    .DEPTH(mtg_pkg::TBL_LEN)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(issue),
    .raddr_a(addr_a),
    .raddr_b(addr_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_active <= 1'b1;
      fill_idx <= '0;
      lcg_x <= mtg_pkg::DEFAULT_SEED | mtg_pkg::WORD_W'(1);
      cur <= mtg_pkg::DEFAULT_SEED | mtg_pkg::WORD_W'(1);
      gen_idx <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (cfg_wen) begin
      // Reseed: drop work in flight and refill the table.
      fill_active <= 1'b1;
      fill_idx <= '0;
      lcg_x <= cfg_wdata | mtg_pkg::WORD_W'(1);
      cur <= cfg_wdata | mtg_pkg::WORD_W'(1);
      gen_idx <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (fill_active) begin
        lcg_x <= lcg_next;
        fill_idx <= fill_idx + 1'b1;
        if (fill_idx == mtg_pkg::IDX_W'(mtg_pkg::TBL_LEN - 1)) begin
          fill_active <= 1'b0;
        end
      end
      s1_v <= issue;
      if (issue) begin
        s1_idx <= gen_idx;
        gen_idx <= gen_idx_next;
      end
      if (s1_v) begin
        cur <= rd_a;
        s2_word <= twist_v;
      end
      s2_v <= s1_v;
    end
  end

  assign fill_busy = fill_active;
  assign push.valid = s2_v;
  assign push.word = mtg_pkg::temper(s2_word);

  a_no_twist_during_fill: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> !fill_active)
    else $error("twist write overlaps table fill");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    (issue && s1_v) |-> (addr_a != s1_idx && addr_b != s1_idx))
    else $error("table read hits the entry being written");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (fifo_count < mtg_pkg::FIFO_CNT_W'(mtg_pkg::FIFO_DEPTH)))
    else $error("word pushed into a full queue");

endmodule

FILE: sv/mtg_fifo.sv
module mtg_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                flush,
  input  mtg_pkg::word_push_t push,
  input  logic                pop,
  output mtg_pkg::fifo_cnt_t  count,
  output mtg_pkg::word_t      head
);

  mtg_pkg::word_t                  mem [mtg_pkg::FIFO_DEPTH];
  logic [mtg_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [mtg_pkg::FIFO_PTR_W-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.word;
    end
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push.valid, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head = mem[rd_ptr];

endmodule

FILE: sv/mersenne_twister_generator_unit.sv
// MT19937 random word source.
// Input channel: in_valid / in_ready with one field, request. An item with
// request set yields one tempered 32-bit word; an item with request clear is
// taken and dropped. Output channel: out_valid / out_ready with random_word.
// A request item's word is loaded into random_word at the edge that accepts
// it and is offered on out_valid in the next cycle. Throughput: one word per
// cycle while the receiver keeps up, set by the single twist step per cycle
// on the two-read, one-write state table (entries k+1 and k+397 read, entry
// k written); a four-entry word queue runs ahead of the requests.
// Seed: cfg_wen with cfg_wdata writes the seed, low bit forced to one.
// Reset loads seed 4357. After reset or a seed write the table is refilled,
// all 624 entries at one entry a cycle, and then the queue primes;
// in_ready stays low meanwhile. Seed writes are taken at any time but are
// meant for an idle block, and discard queued words.
// When the receiver stalls, the word is held in the output register and
// in_ready drops until it is taken; in_ready rises again in the same cycle
// that out_ready takes the held word.
module mersenne_twister_generator_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  request,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           random_word
);

  logic                 fill_busy;
  mtg_pkg::word_push_t  push;
  mtg_pkg::fifo_cnt_t   fifo_count;
  mtg_pkg::word_t       fifo_head;
  logic                 pop;
  logic                 take;

  mtg_engine u_engine (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .fifo_count(fifo_count),
    .fill_busy(fill_busy),
    .push(push)
  );

  mtg_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .flush(cfg_wen),
    .push(push),
    .pop(pop),
    .count(fifo_count),
    .head(fifo_head)
  );

  assign in_ready = !fill_busy && (fifo_count != '0) && (!out_valid || out_ready);
  assign take = in_valid && in_ready;
  assign pop = take && request;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      random_word <= fifo_head;
    end
  end

endmodule

FILE: tb/tb_mersenne_twister_generator_unit.sv
module tb_mersenne_twister_generator_unit;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] random_word;

  mersenne_twister_generator_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .request    (request),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .random_word(random_word)
  );

  always #4 clk = ~clk;

  // Generator model: state table, read position, queue of words still owed
  mtg_pkg::word_t mt_table [mtg_pkg::TBL_LEN];
  int    mt_pos;
  mtg_pkg::word_t pending_words [$];

  int err_cnt = 0;
  int n_words = 0;
  int n_drops = 0;
  int n_seeds = 0;
  int n_checked = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int stall_left = 0;
  mtg_pkg::word_t want_word;

  function automatic void reseed_model(mtg_pkg::word_t s);
    mtg_pkg::word_t x;
    x = s | 32'd1;
    for (int k = 0; k < mtg_pkg::TBL_LEN; k++) begin
      mt_table[k] = x;
      x = x * mtg_pkg::LCG_MUL;
    end
    mt_pos = mtg_pkg::TBL_LEN;
  endfunction

  // Twist in place, in index order, so late entries see already-updated words
  function automatic void twist_table_model();
    mtg_pkg::word_t cur;
    mtg_pkg::word_t nxt;
    mtg_pkg::word_t far;
    mtg_pkg::word_t y;
    mtg_pkg::word_t v;
    for (int k = 0; k < mtg_pkg::TBL_LEN; k++) begin
      cur = mt_table[k];
      nxt = mt_table[(k + 1) % mtg_pkg::TBL_LEN];
      far = mt_table[(k + mtg_pkg::TBL_SHIFT) % mtg_pkg::TBL_LEN];
      y = (cur & mtg_pkg::UPPER_MASK) | (nxt & mtg_pkg::LOWER_MASK);
      v = far ^ (y >> 1);
      if (nxt[0]) v = v ^ mtg_pkg::TWIST_MAT;
      mt_table[k] = v;
    end
    mt_pos = 0;
  endfunction

  function automatic mtg_pkg::word_t temper_word(mtg_pkg::word_t w);
    mtg_pkg::word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic mtg_pkg::word_t next_word_model();
    mtg_pkg::word_t w;
    if (mt_pos >= mtg_pkg::TBL_LEN) twist_table_model();
    w = temper_word(mt_table[mt_pos]);
    mt_pos++;
    return w;
  endfunction

  // Receiver: check each word, then draw a stall before the next one
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      n_checked++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected random_word, expected none, actual %h", $time, random_word);
        err_cnt++;
      end else begin
        want_word = pending_words.pop_front();
        if (random_word !== want_word) begin
          $display("%0t: random_word mismatch, expected %h, actual %h",
                   $time, want_word, random_word);
          err_cnt++;
        end
      end
      stall_left = rx_burst ? 0 : $urandom_range(0, 5);
      out_ready <= (stall_left == 0);
    end else if (!out_ready) begin
      if (stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send_item(bit req);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    request  <= req;
    do @(posedge clk); while (!in_ready);
    if (req) begin
      pending_words.push_back(next_word_model());
      n_words++;
    end else begin
      n_drops++;
    end
  endtask

  // Let all owed words drain, then wait out a dropped item still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(mtg_pkg::word_t s);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_wen <= 1'b0;
    reseed_model(s);
    n_seeds++;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 63) == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      send_item($urandom_range(0, 9) != 0);
    end
  endtask

  // Default seed straight out of reset, with dropped items mixed in
  task automatic test_reset_seed();
    bit pattern [8] = '{1, 1, 0, 1, 0, 0, 1, 1};
    foreach (pattern[i]) send_item(pattern[i]);
  endtask

  // Zero seed (forced odd), all ones, top bit only, even seed
  task automatic test_seed_extremes();
    mtg_pkg::word_t seeds [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h0000_0002};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b1);
    end
  endtask

  // Long stream on the default seed, through the first table regeneration and on toward the second
  task automatic test_long_stream();
    write_seed(mtg_pkg::DEFAULT_SEED);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    run_random(60);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    run_random(640);
  endtask

  task automatic test_random_seeds();
    for (int r = 0; r < 5; r++) begin
      write_seed($urandom);
      tx_burst = (r == 2);
      rx_burst = (r == 3);
      run_random(100);
    end
  endtask

  initial begin
    reseed_model(mtg_pkg::DEFAULT_SEED);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_seed();
    test_seed_extremes();
    test_long_stream();
    test_random_seeds();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("Requested %0d words and checked %0d (%0d dropped requests) over %0d seed writes,",
             n_words, n_checked, n_drops, n_seeds);
    $display("including full table regenerations and random stalls on both sides.");
    if (err_cnt == 0 && pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words still owed", pending_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
